>>> design/tfr_pkg.sv
// ----------------------------------------------------------------------------
// Tile frame reassembler package
// Shared constants, the action codes, the sequencer states and the result
// record passed from the sequencer to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

  // Frame geometry.
  localparam int MAX_TILES     = 64;
  localparam int TILE_CAPACITY = 1024;
  localparam int TILE_W        = $clog2(MAX_TILES);
  localparam int OFF_W         = $clog2(TILE_CAPACITY);
  localparam int FILL_W        = OFF_W + 1;
  localparam int BADDR_W       = TILE_W + OFF_W;
  localparam int CNT_W         = TILE_W + 1;
  localparam int TOTAL_W       = 17;
  localparam int LEN_W         = 32;
  localparam int POS_W         = LEN_W + 1;
  localparam int PREFIX_BYTES  = 4;
  localparam int NONE_MISSING  = MAX_TILES;

  // Requested operation of one input transfer.
  typedef enum logic [1:0] {
    ACT_STORE = 2'd0,
    ACT_JUDGE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL_RD,
    S_FILL_WR,
    S_SCAN,
    S_LEN_RD,
    S_LEN_CHK,
    S_PREFIX,
    S_DECIDE,
    S_WALK_RD,
    S_WALK_CHK,
    S_BYTE_GET,
    S_EMIT
  } state_t;

  // One result item.
  typedef struct packed {
    logic               report_valid;
    logic               complete;
    logic [CNT_W-1:0]   expected_tiles;
    logic [CNT_W-1:0]   present_tiles;
    logic [CNT_W-1:0]   gap_tile;
    logic [TOTAL_W-1:0] total_bytes;
    logic [LEN_W-1:0]   declared_length;
    logic               overflow;
    logic               byte_valid;
    logic [7:0]         payload_byte;
    logic               last_byte;
  } res_t;

endpackage

`default_nettype wire

>>> design/tfr_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered, so it
// appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/tfr_ctrl.sv
// ----------------------------------------------------------------------------
// Tile frame reassembler sequencer
// Runs one request at a time against the fill-length RAM and the byte RAM:
// store read-modify-write, the slot scan for a judge or read, the prefix fetch and
// the tile walk that locates the next payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Request side
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire tfr_pkg::act_t               in_action,
  input  wire logic [tfr_pkg::TILE_W-1:0]  in_tile,
  input  wire logic [7:0]                  in_data,
  // Result side
  input  wire logic                        slot_free,
  output      logic                        res_valid,
  output      tfr_pkg::res_t               res_out,
  // Fill-length RAM
  output      logic                        fill_wr_en,
  output      logic [tfr_pkg::TILE_W-1:0]  fill_wr_addr,
  output      logic [tfr_pkg::FILL_W-1:0]  fill_wr_data,
  output      logic                        fill_rd_en,
  output      logic [tfr_pkg::TILE_W-1:0]  fill_rd_addr,
  input  wire logic [tfr_pkg::FILL_W-1:0]  fill_rd_data,
  // Byte RAM
  output      logic                        byte_wr_en,
  output      logic [tfr_pkg::BADDR_W-1:0] byte_wr_addr,
  output      logic [7:0]                  byte_wr_data,
  output      logic                        byte_rd_en,
  output      logic [tfr_pkg::BADDR_W-1:0] byte_rd_addr,
  input  wire logic [7:0]                  byte_rd_data
);

  import tfr_pkg::*;

  state_t               state, state_next;
  act_t                 act, act_next;
  logic [TILE_W-1:0]    tile, tile_next;
  logic [7:0]           data, data_next;
  logic [MAX_TILES-1:0] nonempty, nonempty_next;
  logic [TOTAL_W-1:0]   total, total_next;
  logic [LEN_W-1:0]     emitted, emitted_next;
  logic                 overflow, overflow_next;
  logic [TILE_W-1:0]    idx, idx_next;
  logic                 any, any_next;
  logic [TILE_W-1:0]    low, low_next;
  logic [TILE_W-1:0]    high, high_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [CNT_W-1:0]     first_empty, first_empty_next;
  logic [LEN_W-1:0]     declared, declared_next;
  logic                 has_prefix, has_prefix_next;
  logic [2:0]           pfx, pfx_next;
  logic [POS_W-1:0]     pos, pos_next;
  res_t                 res, res_next;

  // Working values of the current step.
  logic [FILL_W-1:0]    fill_cur;
  logic [POS_W-1:0]     walk_fill;
  logic [CNT_W-1:0]     expected;
  logic                 complete;

  assign res_out = res;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      nonempty <= '0;
      total    <= '0;
      emitted  <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      nonempty <= nonempty_next;
      total    <= total_next;
      emitted  <= emitted_next;
      overflow <= overflow_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    act         <= act_next;
    tile        <= tile_next;
    data        <= data_next;
    idx         <= idx_next;
    any         <= any_next;
    low         <= low_next;
    high        <= high_next;
    cnt         <= cnt_next;
    first_empty <= first_empty_next;
    declared    <= declared_next;
    has_prefix  <= has_prefix_next;
    pfx         <= pfx_next;
    pos         <= pos_next;
    res         <= res_next;
  end

  // Frame status figures derived from the finished scan. A frame can only be
  // complete once the lowest filled slot carries the whole length prefix.
  always_comb begin
    expected = any ? (CNT_W'(high) + CNT_W'(1)) : '0;
    complete = has_prefix && (total >= TOTAL_W'(PREFIX_BYTES)) &&
               (POS_W'(total) >= (POS_W'(declared) + POS_W'(PREFIX_BYTES)));
  end

  // Next state and outputs.
  always_comb begin
    state_next       = state;
    act_next         = act;
    tile_next        = tile;
    data_next        = data;
    nonempty_next    = nonempty;
    total_next       = total;
    emitted_next     = emitted;
    overflow_next    = overflow;
    idx_next         = idx;
    any_next         = any;
    low_next         = low;
    high_next        = high;
    cnt_next         = cnt;
    first_empty_next = first_empty;
    declared_next    = declared;
    has_prefix_next  = has_prefix;
    pfx_next         = pfx;
    pos_next         = pos;
    res_next         = res;

    in_ready     = 1'b0;
    res_valid    = 1'b0;
    fill_wr_en   = 1'b0;
    fill_wr_addr = tile;
    fill_wr_data = '0;
    fill_rd_en   = 1'b0;
    fill_rd_addr = tile;
    byte_wr_en   = 1'b0;
    byte_wr_addr = '0;
    byte_wr_data = data;
    byte_rd_en   = 1'b0;
    byte_rd_addr = '0;

    fill_cur  = '0;
    walk_fill = '0;

    unique case (state)
      // Take a request; a clear completes here.
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next         = in_action;
          tile_next        = in_tile;
          data_next        = in_data;
          idx_next         = '0;
          any_next         = 1'b0;
          low_next         = '0;
          high_next        = '0;
          cnt_next         = '0;
          first_empty_next = CNT_W'(NONE_MISSING);
          declared_next    = '0;
          has_prefix_next  = 1'b0;
          unique case (in_action)
            ACT_STORE: state_next = S_FILL_RD;
            ACT_CLEAR: begin
              nonempty_next = '0;
              total_next    = '0;
              emitted_next  = '0;
              overflow_next = 1'b0;
            end
            default: state_next = S_SCAN;
          endcase
        end
      end

      // Store: fetch the fill length of the slot.
      S_FILL_RD: begin
        fill_rd_en   = 1'b1;
        fill_rd_addr = tile;
        state_next   = S_FILL_WR;
      end

      // Store: append the byte or flag the drop.
      S_FILL_WR: begin
        fill_cur = nonempty[tile] ? fill_rd_data : '0;
        if (fill_cur >= FILL_W'(TILE_CAPACITY)) begin
          overflow_next = 1'b1;
        end else begin
          byte_wr_en          = 1'b1;
          byte_wr_addr        = {tile, fill_cur[OFF_W-1:0]};
          fill_wr_en          = 1'b1;
          fill_wr_data        = fill_cur + FILL_W'(1);
          nonempty_next[tile] = 1'b1;
          total_next          = total + TOTAL_W'(1);
        end
        state_next = S_IDLE;
      end

      // Judge or read: one slot flag per cycle.
      S_SCAN: begin
        if (nonempty[idx]) begin
          if (!any) begin
            low_next = idx;
          end
          high_next = idx;
          any_next  = 1'b1;
          cnt_next  = cnt + CNT_W'(1);
        end else if (first_empty == CNT_W'(NONE_MISSING)) begin
          first_empty_next = CNT_W'(idx);
        end
        idx_next = idx + TILE_W'(1);
        if (idx == TILE_W'(MAX_TILES - 1)) begin
          state_next = any_next ? S_LEN_RD : S_DECIDE;
        end
      end

      // Judge or read: fill length of the lowest filled slot.
      S_LEN_RD: begin
        fill_rd_en   = 1'b1;
        fill_rd_addr = low;
        state_next   = S_LEN_CHK;
      end

      S_LEN_CHK: begin
        pfx_next        = '0;
        has_prefix_next = (fill_rd_data >= FILL_W'(PREFIX_BYTES));
        state_next = (fill_rd_data >= FILL_W'(PREFIX_BYTES)) ? S_PREFIX : S_DECIDE;
      end

      // Judge or read: four prefix bytes, issued and collected one per cycle.
      S_PREFIX: begin
        if (!pfx[2]) begin
          byte_rd_en   = 1'b1;
          byte_rd_addr = {low, OFF_W'(pfx[1:0])};
        end
        case (pfx)
          3'd1:    declared_next[7:0]   = byte_rd_data;
          3'd2:    declared_next[15:8]  = byte_rd_data;
          3'd3:    declared_next[23:16] = byte_rd_data;
          3'd4:    declared_next[31:24] = byte_rd_data;
          default: declared_next        = declared;
        endcase
        pfx_next = pfx + 3'd1;
        if (pfx == 3'd4) begin
          state_next = S_DECIDE;
        end
      end

      // Form the report, or start the walk for a read; a read with no byte due gets an empty result.
      S_DECIDE: begin
        res_next          = '0;
        res_next.overflow = overflow;
        if (act == ACT_JUDGE) begin
          res_next.report_valid    = 1'b1;
          res_next.complete        = complete;
          res_next.expected_tiles  = expected;
          res_next.present_tiles   = cnt;
          res_next.gap_tile        = (first_empty < expected) ? first_empty
                                                              : CNT_W'(NONE_MISSING);
          res_next.total_bytes     = total;
          res_next.declared_length = declared;
          state_next               = S_EMIT;
        end else if (complete && (emitted < declared)) begin
          idx_next   = '0;
          pos_next   = POS_W'(emitted) + POS_W'(PREFIX_BYTES);
          state_next = S_WALK_RD;
        end else begin
          state_next = S_EMIT;
        end
      end

      // Read: fetch the next slot length.
      S_WALK_RD: begin
        fill_rd_en   = 1'b1;
        fill_rd_addr = idx;
        state_next   = S_WALK_CHK;
      end

      // Read: stop in the slot that holds the position, else step past it.
      S_WALK_CHK: begin
        walk_fill = nonempty[idx] ? POS_W'(fill_rd_data) : '0;
        if (pos < walk_fill) begin
          byte_rd_en   = 1'b1;
          byte_rd_addr = {idx, pos[OFF_W-1:0]};
          state_next   = S_BYTE_GET;
        end else if (idx == TILE_W'(MAX_TILES - 1)) begin
          state_next = S_EMIT;
        end else begin
          pos_next   = pos - walk_fill;
          idx_next   = idx + TILE_W'(1);
          state_next = S_WALK_RD;
        end
      end

      // Read: the payload byte is back.
      S_BYTE_GET: begin
        res_next.byte_valid   = 1'b1;
        res_next.payload_byte = byte_rd_data;
        res_next.last_byte    = ((POS_W'(emitted) + POS_W'(1)) == POS_W'(declared));
        emitted_next          = emitted + LEN_W'(1);
        state_next            = S_EMIT;
      end

      // Hand the result to the output register.
      S_EMIT: begin
        if (slot_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/tile_frame_reassembler_top.sv
// Store: fill read, then byte and fill write; a clear completes in the idle state.
// Judge: slot scan, length check, prefix fetch (skipped without a full prefix), report.
// Read: the judge's scan and prefix fetch, a length check per slot walked, the byte fetch.
// One request is worked on at a time; a finished result waits in the output register,
// and a result held back by the output stream adds its stall cycles to the request.
// Reset clears control state and marks every slot empty; the byte RAM is not cleared.
// ----------------------------------------------------------------------------
// Tile frame reassembler
// Collects frame bytes into indexed tile slots, judges the frame and streams
// the payload in tile order after the length prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_frame_reassembler_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // tile[5:0], data[13:6], zero fill
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  // Result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [79:0] m_axis_tdata,  // complete[0], expected_tiles[7:1],
                                          // present_tiles[14:8], gap_tile[21:15],
                                          // total_bytes[38:22], declared_length[70:39],
                                          // overflow[71], payload_byte[79:72]
  output      logic [1:0]  m_axis_tuser,  // report_valid[0], byte_valid[1]
  output      logic        m_axis_tlast   // last_byte
);

  import tfr_pkg::*;

  logic                slot_free;
  logic                res_valid;
  res_t                res;
  res_t                out_res;
  logic                out_full;

  logic                fill_wr_en;
  logic [TILE_W-1:0]   fill_wr_addr;
  logic [FILL_W-1:0]   fill_wr_data;
  logic                fill_rd_en;
  logic [TILE_W-1:0]   fill_rd_addr;
  logic [FILL_W-1:0]   fill_rd_data;
  logic                byte_wr_en;
  logic [BADDR_W-1:0]  byte_wr_addr;
  logic [7:0]          byte_wr_data;
  logic                byte_rd_en;
  logic [BADDR_W-1:0]  byte_rd_addr;
  logic [7:0]          byte_rd_data;

  // Request sequencer.
  tfr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_action    (act_t'(s_axis_tuser)),
    .in_tile      (s_axis_tdata[5:0]),
    .in_data      (s_axis_tdata[13:6]),
    .slot_free    (slot_free),
    .res_valid    (res_valid),
    .res_out      (res),
    .fill_wr_en   (fill_wr_en),
    .fill_wr_addr (fill_wr_addr),
    .fill_wr_data (fill_wr_data),
    .fill_rd_en   (fill_rd_en),
    .fill_rd_addr (fill_rd_addr),
    .fill_rd_data (fill_rd_data),
    .byte_wr_en   (byte_wr_en),
    .byte_wr_addr (byte_wr_addr),
    .byte_wr_data (byte_wr_data),
    .byte_rd_en   (byte_rd_en),
    .byte_rd_addr (byte_rd_addr),
    .byte_rd_data (byte_rd_data)
  );

  // Per-slot fill lengths.
  tfr_ram #(
    .DATA_W (FILL_W),
    .ADDR_W (TILE_W)
  ) u_fill_ram (
    .clk     (clk),
    .wr_en   (fill_wr_en),
    .wr_addr (fill_wr_addr),
    .wr_data (fill_wr_data),
    .rd_en   (fill_rd_en),
    .rd_addr (fill_rd_addr),
    .rd_data (fill_rd_data)
  );

  // Slot byte storage, addressed by tile and offset.
  tfr_ram #(
    .DATA_W (8),
    .ADDR_W (BADDR_W)
  ) u_byte_ram (
    .clk     (clk),
    .wr_en   (byte_wr_en),
    .wr_addr (byte_wr_addr),
    .wr_data (byte_wr_data),
    .rd_en   (byte_rd_en),
    .rd_addr (byte_rd_addr),
    .rd_data (byte_rd_data)
  );

  // Output register: a new result may load as the held one transfers.
  assign slot_free = !out_full || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  // Result stream packing.
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {out_res.payload_byte, out_res.overflow, out_res.declared_length,
                          out_res.total_bytes, out_res.gap_tile,
                          out_res.present_tiles, out_res.expected_tiles,
                          out_res.complete};
  assign m_axis_tuser  = {out_res.byte_valid, out_res.report_valid};
  assign m_axis_tlast  = out_res.last_byte;

endmodule

`default_nettype wire

>>> design/tfr_checker.sv
// ----------------------------------------------------------------------------
// Tile frame reassembler port checker
// Watches the top level's streams and checks result framing and the
// one-request-at-a-time acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [79:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser,
  input  wire logic        m_axis_tlast
);

  import tfr_pkg::*;

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // The last payload byte is a valid byte and never a report.
  a_last_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1] && !m_axis_tuser[0])
    else $error("last byte marked on a non-byte result");

  // A judge or read request holds off the next request: ready drops after it is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
    (s_axis_tuser == ACT_JUDGE || s_axis_tuser == ACT_READ) |=> !s_axis_tready)
    else $error("request taken while a judge or read is in progress");

endmodule

bind tile_frame_reassembler_top tfr_checker u_tfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> tb/tb_tile_frame_reassembler_top.sv
// ----------------------------------------------------------------------------
// Testbench for the tile frame reassembler
// Drives store, judge, read and clear requests into the request stream and
// checks every report and payload byte against a behavioral model of the
// tile slots that runs alongside the block. Directed cases come first, then a
// full-tile case, then random frames scattered over the slots in random order
// together with broken frames and noise. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module tb_tile_frame_reassembler_top;
  import tfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 600;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // tile[5:0], data[13:6], zero fill
  logic [1:0]  s_axis_tuser;   // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;   // complete[0], expected_tiles[7:1], present_tiles[14:8],
                               // gap_tile[21:15], total_bytes[38:22],
                               // declared_length[70:39], overflow[71], payload_byte[79:72]
  logic [1:0]  m_axis_tuser;   // report_valid[0], byte_valid[1]
  logic        m_axis_tlast;   // last_byte

  tile_frame_reassembler_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Model of the tile slots.
  logic [7:0]       slot_mem [MAX_TILES*TILE_CAPACITY];
  int unsigned      slot_fill [MAX_TILES];
  int unsigned      byte_count;
  logic [POS_W-1:0] emitted_count;
  bit               slot_overflow;

  // Results still owed by the block, oldest first.
  res_t frame_result_q [$];

  int          mismatches = 0;
  int          items_sent = 0;
  int          reports_seen = 0;
  int          bytes_seen = 0;
  int          empty_reads_seen = 0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  // Empty every slot and rewind the read cursor.
  function automatic void clear_slots();
    for (int i = 0; i < MAX_TILES; i++) slot_fill[i] = 0;
    byte_count = 0;
    emitted_count = '0;
    slot_overflow = 1'b0;
  endfunction

  // Apply one request to the model; returns 1 when the request yields a result.
  function automatic bit compute_frame_response(input act_t act, input logic [5:0] tile,
                                                input logic [7:0] data, output res_t resp);
    int unsigned     highest;
    int unsigned     lowest;
    int unsigned     present;
    int unsigned     missing;
    int              base;
    bit              any;
    bit              complete;
    bit              found;
    logic [31:0]     decl;
    longint unsigned pos;
    resp = '0;
    if (act == ACT_STORE) begin
      if (slot_fill[tile] >= TILE_CAPACITY) begin
        slot_overflow = 1'b1;
      end else begin
        slot_mem[int'(tile)*TILE_CAPACITY + slot_fill[tile]] = data;
        slot_fill[tile]++;
        byte_count++;
      end
      return 1'b0;
    end
    if (act == ACT_CLEAR) begin
      clear_slots();
      return 1'b0;
    end

    // Frame status, needed by both judge and read.
    any = 1'b0;
    highest = 0;
    lowest = 0;
    present = 0;
    missing = NONE_MISSING;
    decl = '0;
    complete = 1'b0;
    for (int i = 0; i < MAX_TILES; i++) begin
      if (slot_fill[i] != 0) begin
        if (!any) lowest = i;
        highest = i;
        any = 1'b1;
      end
    end
    if (any) begin
      for (int i = 0; i <= int'(highest); i++) begin
        if (slot_fill[i] == 0) begin
          if (missing == NONE_MISSING) missing = i;
        end else begin
          present++;
        end
      end
      if (slot_fill[lowest] >= PREFIX_BYTES) begin
        base = lowest * TILE_CAPACITY;
        decl = {slot_mem[base+3], slot_mem[base+2], slot_mem[base+1], slot_mem[base]};
        complete = 64'(byte_count) >= 64'(decl) + 64'd4;
      end
    end
    resp.overflow = slot_overflow;

    if (act == ACT_JUDGE) begin
      resp.report_valid    = 1'b1;
      resp.complete        = complete;
      resp.expected_tiles  = any ? CNT_W'(highest + 1) : '0;
      resp.present_tiles   = CNT_W'(present);
      resp.gap_tile        = CNT_W'(missing);
      resp.total_bytes     = TOTAL_W'(byte_count);
      resp.declared_length = decl;
      return 1'b1;
    end

    // Read: walk the slots in index order to the next payload position.
    if (complete && emitted_count < {1'b0, decl}) begin
      pos = 64'(emitted_count) + PREFIX_BYTES;
      found = 1'b0;
      for (int i = 0; i < MAX_TILES; i++) begin
        if (!found) begin
          if (pos < slot_fill[i]) begin
            resp.byte_valid   = 1'b1;
            resp.payload_byte = slot_mem[i*TILE_CAPACITY + int'(pos)];
            resp.last_byte    = (emitted_count + 1 == {1'b0, decl});
            emitted_count++;
            found = 1'b1;
          end else begin
            pos -= slot_fill[i];
          end
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Send one request and wait for its transfer, then sometimes idle for a random gap.
  task automatic send_item(input act_t act, input logic [5:0] tile, input logic [7:0] data);
    res_t resp;
    int   gap;
    int   roll;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, data, tile};
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (compute_frame_response(act, tile, data, resp)) frame_result_q.push_back(resp);
    items_sent++;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 70) gap = 0;
    else if (roll < 96) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 30);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the request stream idle until every owed result has arrived.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (frame_result_q.size() != 0) @(posedge clk);
  endtask

  // Judge and read on a frame with nothing stored.
  task automatic test_empty_frame();
    send_item(ACT_JUDGE, 6'd0, 8'd0);
    send_item(ACT_READ, 6'd63, 8'hFF);
  endtask

  // Tiles stored out of order, with an empty slot below the lowest filled one.
  task automatic test_scattered_tiles();
    send_item(ACT_STORE, 6'd3, 8'h00);
    send_item(ACT_STORE, 6'd1, 8'h02);
    send_item(ACT_STORE, 6'd1, 8'h00);
    send_item(ACT_STORE, 6'd3, 8'h7E);
    send_item(ACT_STORE, 6'd1, 8'h00);
    send_item(ACT_STORE, 6'd1, 8'h00);
    send_item(ACT_STORE, 6'd1, 8'hFF);
    send_item(ACT_JUDGE, 6'd0, 8'd0);
    repeat (3) send_item(ACT_READ, 6'd0, 8'd0);
    wait_for_results();
  endtask

  // A prefix cut short, then a zero declared length in the top slot.
  task automatic test_short_prefix();
    send_item(ACT_CLEAR, 6'd0, 8'd0);
    send_item(ACT_STORE, 6'd63, 8'h00);
    send_item(ACT_STORE, 6'd63, 8'h00);
    send_item(ACT_JUDGE, 6'd0, 8'd0);
    send_item(ACT_READ, 6'd0, 8'd0);
    send_item(ACT_STORE, 6'd63, 8'h00);
    send_item(ACT_STORE, 6'd63, 8'h00);
    send_item(ACT_JUDGE, 6'd0, 8'd0);
    send_item(ACT_READ, 6'd0, 8'd0);
  endtask

  // Reads that are refused while incomplete, and stores that land between reads.
  task automatic test_store_between_reads();
    send_item(ACT_CLEAR, 6'd0, 8'd0);
    send_item(ACT_STORE, 6'd0, 8'h02);
    send_item(ACT_STORE, 6'd0, 8'h00);
    send_item(ACT_STORE, 6'd0, 8'h00);
    send_item(ACT_STORE, 6'd0, 8'h00);
    send_item(ACT_STORE, 6'd0, 8'h11);
    send_item(ACT_READ, 6'd0, 8'd0);
    send_item(ACT_STORE, 6'd2, 8'h33);
    send_item(ACT_READ, 6'd0, 8'd0);
    send_item(ACT_STORE, 6'd1, 8'h22);
    send_item(ACT_READ, 6'd0, 8'd0);
    send_item(ACT_READ, 6'd0, 8'd0);
    wait_for_results();
  endtask

  // Fill one slot past its capacity; the overflow flag sticks until a clear.
  task automatic test_tile_overflow();
    send_item(ACT_CLEAR, 6'd0, 8'd0);
    for (int i = 0; i < TILE_CAPACITY + 4; i++) begin
      if (i == 0) send_item(ACT_STORE, 6'd40, 8'h03);
      else if (i < PREFIX_BYTES) send_item(ACT_STORE, 6'd40, 8'h00);
      else send_item(ACT_STORE, 6'd40, 8'($urandom));
    end
    send_item(ACT_JUDGE, 6'd0, 8'd0);
    repeat (4) send_item(ACT_READ, 6'd0, 8'd0);
    send_item(ACT_STORE, 6'd41, 8'h5A);
    send_item(ACT_JUDGE, 6'd0, 8'd0);
    send_item(ACT_CLEAR, 6'd0, 8'd0);
    send_item(ACT_JUDGE, 6'd0, 8'd0);
    wait_for_results();
  endtask

  // Random frames spread over the slots, broken frames and random noise.
  task automatic test_random_frames(input int item_budget);
    logic [7:0]  fbytes [$];
    logic [5:0]  ctile [6];
    int          clen [6];
    int          cbase [6];
    int          cptr [6];
    int          stop_at;
    int          nch;
    int          len;
    int          extra;
    int          t;
    int          c;
    int          left;
    int          remaining;
    int          mode;
    int          k;
    logic [31:0] decl;
    bit          split_prefix;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        // Noise: any request with any fields.
        repeat ($urandom_range(5, 20)) begin
          k = $urandom_range(0, 15);
          send_item(k < 7 ? ACT_STORE : k < 10 ? ACT_JUDGE : k < 15 ? ACT_READ : ACT_CLEAR,
                    6'($urandom), 8'($urandom));
        end
      end else begin
        if ($urandom_range(0, 9) != 0) send_item(ACT_CLEAR, 6'($urandom), 8'($urandom));
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 160) : $urandom_range(0, 24);
        decl = len;
        split_prefix = 1'b0;
        // A broken frame declares more than it carries or splits its prefix.
        if (mode == 1) begin
          case ($urandom_range(0, 2))
            0: decl = len + $urandom_range(1, 5);
            1: decl = $urandom();
            default: split_prefix = 1'b1;
          endcase
        end
        fbytes = {};
        for (k = 0; k < PREFIX_BYTES; k++) fbytes.push_back(decl[8*k +: 8]);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (len + extra) fbytes.push_back(8'($urandom));

        // Pick increasing slot indexes, sometimes with empty slots between.
        nch = $urandom_range(1, 5);
        t = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 2);
        for (c = 0; c < nch; c++) begin
          ctile[c] = 6'(t);
          if (t + 4 > 63) begin
            nch = c + 1;
            break;
          end
          t += ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
        end

        // Cut the byte string into one chunk per slot.
        remaining = fbytes.size();
        for (c = 0; c < nch; c++) begin
          if (c == nch - 1) clen[c] = remaining;
          else if (c == 0) clen[c] = split_prefix ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 4 + len / 2);
          else clen[c] = $urandom_range(0, remaining / 2 + 1);
          if (clen[c] > remaining) clen[c] = remaining;
          cbase[c] = fbytes.size() - remaining;
          cptr[c] = 0;
          remaining -= clen[c];
        end

        // Store the chunks interleaved in random slot order.
        left = fbytes.size();
        while (left > 0) begin
          c = $urandom_range(0, nch - 1);
          if (cptr[c] < clen[c]) begin
            send_item(ACT_STORE, ctile[c], fbytes[cbase[c] + cptr[c]]);
            cptr[c]++;
            left--;
            if ($urandom_range(0, 19) == 0) send_item(ACT_JUDGE, 6'($urandom), 8'($urandom));
          end
        end
        send_item(ACT_JUDGE, 6'($urandom), 8'($urandom));

        // Read the payload and one or two past its end.
        repeat (len + $urandom_range(1, 2)) begin
          k = $urandom_range(0, 39);
          if (k == 0) send_item(ACT_STORE, 6'($urandom_range(0, 7)), 8'($urandom));
          else if (k < 3) send_item(ACT_JUDGE, 6'($urandom), 8'($urandom));
          send_item(ACT_READ, 6'($urandom), 8'($urandom));
        end
      end
      if ($urandom_range(0, 7) == 0) wait_for_results();
      if ($urandom_range(0, 5) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 5) == 0) rx_steady = !rx_steady;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result-side ready: mostly high, with short and occasional long stalls.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_steady) begin
        case ($urandom_range(0, 99)) inside
          [0:11]:  stall_left <= $urandom_range(1, 3);
          [12:13]: stall_left <= $urandom_range(15, 40);
          default: stall_left <= 0;
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest owed result.
  always @(posedge clk) begin
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frame_result_q.size() == 0) begin
        $error("result transfer with no result owed");
        mismatches++;
      end else begin
        want = frame_result_q.pop_front();
        compare_field("report_valid", want.report_valid, m_axis_tuser[0]);
        compare_field("complete", want.complete, m_axis_tdata[0]);
        compare_field("expected_tiles", want.expected_tiles, m_axis_tdata[7:1]);
        compare_field("present_tiles", want.present_tiles, m_axis_tdata[14:8]);
        compare_field("gap_tile", want.gap_tile, m_axis_tdata[21:15]);
        compare_field("total_bytes", want.total_bytes, m_axis_tdata[38:22]);
        compare_field("declared_length", want.declared_length, m_axis_tdata[70:39]);
        compare_field("overflow", want.overflow, m_axis_tdata[71]);
        compare_field("byte_valid", want.byte_valid, m_axis_tuser[1]);
        compare_field("payload_byte", want.payload_byte, m_axis_tdata[79:72]);
        compare_field("last_byte", want.last_byte, m_axis_tlast);
        if (want.report_valid) reports_seen++;
        else if (want.byte_valid) bytes_seen++;
        else empty_reads_seen++;
      end
    end
  end

  // Cycle counter and run limit.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Test sequence.
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_STORE;
    clear_slots();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_frame();
    test_scattered_tiles();
    test_short_prefix();
    test_store_between_reads();
    test_tile_overflow();
    test_random_frames(RANDOM_ITEMS);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_result_q.size() != 0) begin
      $error("%0d results never arrived", frame_result_q.size());
      mismatches++;
    end

    $display("Sent %0d requests; checked %0d judge reports, %0d payload bytes and %0d empty reads.",
             items_sent, reports_seen, bytes_seen, empty_reads_seen);
    $display("Covered scattered tiles, short prefixes, a full slot and reads between stores.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> tile_frame_reassembler_top.f
design/tfr_pkg.sv
design/tfr_ram.sv
design/tfr_ctrl.sv
design/tile_frame_reassembler_top.sv
design/tfr_checker.sv
tb/tb_tile_frame_reassembler_top.sv
